### src/pid_filtered_derivative_macros.svh
// Assertion macros shared by the PID filtered-derivative RTL.
`ifndef PID_FILTERED_DERIVATIVE_MACROS_SVH
`define PID_FILTERED_DERIVATIVE_MACROS_SVH
`ifndef SYNTHESIS
// Check on the rising clock, held off while reset is high.
`define PIDFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check on the rising clock, also checked across reset.
`define PIDFD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PIDFD_ASSERT(lbl, prop, msg)
`define PIDFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/pidfd_pkg.sv
// Shared widths, constants and types of the PID filtered-derivative block.
`timescale 1ns / 1ps
package pidfd_pkg;

   // Q16.16 signal format
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int TS_W   = 24;
   localparam int TAU_W  = 31;

   // Serial multiplier: operands up to 34 bits signed, magnitudes 33 bits
   localparam int OPND_W = 34;
   localparam int MAG_W  = 33;
   localparam int PROD_W = 2 * MAG_W;

   // Serial divider: |num| << FRAC_W over a 33-bit divisor
   localparam int DIVD_W = DATA_W + FRAC_W;
   localparam int DEN_W  = 33;

   // Step counter, wide enough for the longer of the two loops
   localparam int CNT_W = $clog2(DIVD_W);

   // Configuration index width
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] Q_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] Q_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic        [DATA_W-1:0] QMIN_MAG = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] q_type;
   typedef logic signed [OPND_W-1:0] opnd_type;

   // Right shift applied to a finished product
   typedef enum logic [1:0] {
      SHIFT_FRAC_M1,
      SHIFT_FRAC,
      SHIFT_FRAC_P1
   } shift_type;

   // Multiplier launch control
   typedef struct packed {
      logic      start;
      shift_type shift;
   } mul_ctrl_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_PROP,
      REG_GAIN_INTEGRAL,
      REG_GAIN_DERIV,
      REG_FILTER_TAU,
      REG_INTEG_MAX,
      REG_INTEG_MIN,
      REG_DRIVE_MAX,
      REG_DRIVE_MIN
   } csr_index_type;

endpackage

### src/pidfd_mul.sv
// Shift-add serial multiplier: one multiplier bit per cycle, scaled and saturated result.
`timescale 1ns / 1ps
`include "pid_filtered_derivative_macros.svh"
module pidfd_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  pidfd_pkg::mul_ctrl_type ctrl,
   input  pidfd_pkg::opnd_type   op_a,
   input  pidfd_pkg::opnd_type   op_b,
   output logic                  done,
   output pidfd_pkg::q_type      result
);
   import pidfd_pkg::*;

   logic [MAG_W-1:0]  mag_a_in;
   logic [MAG_W-1:0]  mag_b_in;
   logic [MAG_W-1:0]  mcand_ff;
   logic [MAG_W-1:0]  mplier_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [PROD_W-1:0] acc_in;
   logic [PROD_W-1:0] shifted;
   logic [MAG_W:0]    psum;
   logic              neg_ff;
   logic              busy_ff;
   logic              fin_ff;
   logic              done_ff;
   shift_type         shift_ff;
   logic [CNT_W-1:0]  cnt_ff;
   q_type             result_ff;
   q_type             result_in;

   // Operand magnitudes
   assign mag_a_in = op_a[OPND_W-1] ? MAG_W'(-op_a) : MAG_W'(op_a);
   assign mag_b_in = op_b[OPND_W-1] ? MAG_W'(-op_b) : MAG_W'(op_b);

   // One partial product per cycle, accumulator shifts right
   assign psum   = (MAG_W+1)'(acc_ff[PROD_W-1:MAG_W])
                 + (mplier_ff[0] ? (MAG_W+1)'(mcand_ff) : '0);
   assign acc_in = {psum, acc_ff[MAG_W-1:1]};

   // Scale, truncate toward zero, saturate, apply sign
   always_comb begin
      case (shift_ff)
         SHIFT_FRAC_M1: shifted = acc_ff >> (FRAC_W - 1);
         SHIFT_FRAC:    shifted = acc_ff >> FRAC_W;
         SHIFT_FRAC_P1: shifted = acc_ff >> (FRAC_W + 1);
         default:       shifted = acc_ff >> FRAC_W;
      endcase
      if (!neg_ff) begin
         result_in = (shifted > PROD_W'(Q_MAX)) ? Q_MAX : $signed(shifted[DATA_W-1:0]);
      end else begin
         result_in = (shifted > PROD_W'(QMIN_MAG)) ? Q_MIN : $signed(-shifted[DATA_W-1:0]);
      end
   end

   // Sequencing of load, accumulate and finish
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            mcand_ff  <= mag_a_in;
            mplier_ff <= mag_b_in;
            neg_ff    <= op_a[OPND_W-1] ^ op_b[OPND_W-1];
            shift_ff  <= ctrl.shift;
            acc_ff    <= '0;
            cnt_ff    <= '0;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            acc_ff    <= acc_in;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff    <= 1'b0;
            done_ff   <= 1'b1;
            result_ff <= result_in;
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

   `PIDFD_ASSERT(a_mul_no_restart, ctrl.start |-> !busy_ff && !fin_ff, "multiply restarted")
   `PIDFD_ASSERT_ALWAYS(a_mul_reset_idle, reset |=> !busy_ff && !fin_ff && !done_ff, "busy after reset")

endmodule

### src/pidfd_div.sv
// Restoring serial divider for the derivative filter: one quotient bit per cycle.
`timescale 1ns / 1ps
`include "pid_filtered_derivative_macros.svh"
module pidfd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pidfd_pkg::q_type       num,
   input  logic [pidfd_pkg::DEN_W-1:0] den,
   output logic                   done,
   output pidfd_pkg::q_type       result
);
   import pidfd_pkg::*;

   logic [DIVD_W-1:0] dvd_ff;
   logic [DIVD_W-1:0] quo_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W:0]    trial;
   logic              qbit;
   logic [DATA_W-1:0] num_mag;
   logic              neg_ff;
   logic              zero_ff;
   logic              busy_ff;
   logic              fin_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   q_type             qclip;
   q_type             result_ff;
   q_type             result_in;

   assign num_mag = num[DATA_W-1] ? -num : num;

   // Trial subtract of the next dividend bit
   assign trial  = {rem_ff, dvd_ff[DIVD_W-1]};
   assign qbit   = trial >= {1'b0, den_ff};
   assign rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);

   // Saturate, then the filter output takes the opposite sign of the numerator; a zero divisor gives zero
   always_comb begin
      qclip = (quo_ff > DIVD_W'(Q_MAX)) ? Q_MAX : $signed(quo_ff[DATA_W-1:0]);
      if (zero_ff) begin
         result_in = '0;
      end else if (neg_ff) begin
         result_in = qclip;
      end else begin
         result_in = -qclip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= {num_mag, {FRAC_W{1'b0}}};
            quo_ff  <= '0;
            rem_ff  <= '0;
            den_ff  <= den;
            neg_ff  <= num[DATA_W-1];
            zero_ff <= (den == '0);
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_ff << 1;
            quo_ff <= {quo_ff[DIVD_W-2:0], qbit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff    <= 1'b0;
            done_ff   <= 1'b1;
            result_ff <= result_in;
         end
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

   `PIDFD_ASSERT(a_div_no_restart, start |-> !busy_ff && !fin_ff, "divide restarted")

endmodule

### src/pid_filtered_derivative.sv
// Top level of the PID controller with trapezoidal integrator and filtered derivative.
//
//  channel | ports                                    | role
//  --------+------------------------------------------+--------------------------------
//  req     | req_valid/req_ready, kind, target, ...    | update or clear item in
//  rsp     | rsp_valid/rsp_ready, drive, drive_clamped | one result per update item
//  csr     | csr_valid/csr_ready, csr_index, csr_data  | register write, always ready
//
//  An update runs five passes of the shared 33-step serial multiplier, one 48-step
//  serial divide, and an accept, a sum and a clamp step. A clear item gives no result.
//  The result waits in an output register; the next item is taken while it waits,
//  and a finished update holds before the output register until that register is free.
//  Reset is synchronous: registers return to their reset values, state is zeroed.
`timescale 1ns / 1ps
`include "pid_filtered_derivative_macros.svh"
module pid_filtered_derivative (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [31:0]            req_target,
   input  logic signed [31:0]            req_measured,
   input  logic [pidfd_pkg::TS_W-1:0]    req_sample_time,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_drive,
   output logic                          rsp_drive_clamped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pidfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);
   import pidfd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROP,  S_PROP_W,
      S_KITS,  S_KITS_W,
      S_ITERM, S_ITERM_W,
      S_T1,    S_T1_W,
      S_T2,    S_T2_W,
      S_DIV,   S_DIV_W,
      S_SUM,
      S_DRIVE
   } state_type;

   // Saturate a widened sum to the Q16.16 range
   function automatic q_type sat_q(input logic signed [OPND_W-1:0] v);
      if (v > OPND_W'(Q_MAX)) begin
         return Q_MAX;
      end else if (v < OPND_W'(Q_MIN)) begin
         return Q_MIN;
      end else begin
         return DATA_W'(v);
      end
   endfunction

   state_type         state_ff;

   // Configuration registers
   q_type             kp_ff, ki_ff, kd_ff;
   logic [TAU_W-1:0]  tau_ff;
   q_type             imax_ff, imin_ff, omax_ff, omin_ff;

   // Controller state
   q_type             integ_acc_ff, last_error_ff, deriv_acc_ff, last_meas_ff;

   // Per-update working registers
   q_type             err_ff, meas_ff;
   logic signed [DATA_W:0] dmeas_ff, esum_ff;
   logic [TS_W-1:0]   ts_ff;
   opnd_type          coef_ff;
   logic [DEN_W-1:0]  den_ff;
   q_type             prop_ff, kits_ff, iterm_ff, integ_ff, t1_ff, num_ff, d_ff, sum_ff;

   // Output register
   logic              rsp_valid_ff;
   q_type             rsp_drive_ff;
   logic              rsp_clamped_ff;

   // Next values
   q_type             err_in;
   logic signed [DATA_W:0] dmeas_in;
   q_type             integ_sat;
   q_type             integ_in;
   q_type             num_in;
   q_type             sum_in;

   // Unit interfaces
   mul_ctrl_type      mul_ctrl;
   opnd_type          mul_a, mul_b;
   logic              mul_done;
   q_type             mul_result;
   logic              div_start;
   logic              div_done;
   q_type             div_result;
   logic              out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Error and measurement step at transfer
   assign err_in   = sat_q(OPND_W'(req_target) - OPND_W'(req_measured));
   assign dmeas_in = (DATA_W+1)'(req_measured) - (DATA_W+1)'(last_meas_ff);

   // Integrator update with anti-windup clamp, upper limit first
   assign integ_sat = sat_q(OPND_W'(integ_acc_ff) + OPND_W'(iterm_ff));
   always_comb begin
      if (integ_sat > imax_ff) begin
         integ_in = imax_ff;
      end else if (integ_sat < imin_ff) begin
         integ_in = imin_ff;
      end else begin
         integ_in = integ_sat;
      end
   end

   assign num_in = sat_q(OPND_W'(t1_ff) + OPND_W'(mul_result));
   assign sum_in = sat_q(OPND_W'(prop_ff) + OPND_W'(integ_ff) + OPND_W'(d_ff));

   // Multiplier operand selection per step
   always_comb begin
      mul_ctrl.start = 1'b0;
      mul_ctrl.shift = SHIFT_FRAC;
      mul_a          = '0;
      mul_b          = '0;
      case (state_ff)
         S_PROP: begin
            mul_ctrl.start = 1'b1;
            mul_a          = OPND_W'(kp_ff);
            mul_b          = OPND_W'(err_ff);
         end
         S_KITS: begin
            mul_ctrl.start = 1'b1;
            mul_a          = OPND_W'(ki_ff);
            mul_b          = OPND_W'(ts_ff);
         end
         S_ITERM: begin
            mul_ctrl.start = 1'b1;
            mul_ctrl.shift = SHIFT_FRAC_P1;
            mul_a          = OPND_W'(kits_ff);
            mul_b          = OPND_W'(esum_ff);
         end
         S_T1: begin
            mul_ctrl.start = 1'b1;
            mul_ctrl.shift = SHIFT_FRAC_M1;
            mul_a          = OPND_W'(kd_ff);
            mul_b          = OPND_W'(dmeas_ff);
         end
         S_T2: begin
            mul_ctrl.start = 1'b1;
            mul_a          = coef_ff;
            mul_b          = OPND_W'(deriv_acc_ff);
         end
         default: begin
            mul_ctrl.start = 1'b0;
         end
      endcase
   end

   assign div_start = (state_ff == S_DIV);

   pidfd_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mul_ctrl),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_result)
   );

   pidfd_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_ff),
      .den    (den_ff),
      .done   (div_done),
      .result (div_result)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         tau_ff  <= '0;
         imax_ff <= Q_MAX;
         imin_ff <= Q_MIN;
         omax_ff <= Q_MAX;
         omin_ff <= Q_MIN;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_GAIN_PROP:     kp_ff   <= csr_data;
            REG_GAIN_INTEGRAL: ki_ff   <= csr_data;
            REG_GAIN_DERIV:    kd_ff   <= csr_data;
            REG_FILTER_TAU:    tau_ff  <= csr_data[TAU_W-1:0];
            REG_INTEG_MAX:     imax_ff <= csr_data;
            REG_INTEG_MIN:     imin_ff <= csr_data;
            REG_DRIVE_MAX:     omax_ff <= csr_data;
            REG_DRIVE_MIN:     omin_ff <= csr_data;
            default:           kp_ff   <= kp_ff;
         endcase
      end
   end

   // Step sequencer, controller state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         integ_acc_ff  <= '0;
         last_error_ff <= '0;
         deriv_acc_ff  <= '0;
         last_meas_ff  <= '0;
      end else begin
         // a new result in S_DRIVE takes over the output register instead
         if (rsp_valid_ff && rsp_ready && state_ff != S_DRIVE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_kind) begin
                     integ_acc_ff  <= '0;
                     last_error_ff <= '0;
                     deriv_acc_ff  <= '0;
                     last_meas_ff  <= '0;
                  end else begin
                     err_ff   <= err_in;
                     dmeas_ff <= dmeas_in;
                     meas_ff  <= req_measured;
                     ts_ff    <= req_sample_time;
                     state_ff <= S_PROP;
                  end
               end
            end
            S_PROP: begin
               esum_ff  <= (DATA_W+1)'(err_ff) + (DATA_W+1)'(last_error_ff);
               coef_ff  <= $signed(OPND_W'({tau_ff, 1'b0})) - $signed(OPND_W'(ts_ff));
               den_ff   <= DEN_W'({tau_ff, 1'b0}) + DEN_W'(ts_ff);
               state_ff <= S_PROP_W;
            end
            S_PROP_W: begin
               if (mul_done) begin
                  prop_ff  <= mul_result;
                  state_ff <= S_KITS;
               end
            end
            S_KITS: state_ff <= S_KITS_W;
            S_KITS_W: begin
               if (mul_done) begin
                  kits_ff  <= mul_result;
                  state_ff <= S_ITERM;
               end
            end
            S_ITERM: state_ff <= S_ITERM_W;
            S_ITERM_W: begin
               if (mul_done) begin
                  iterm_ff <= mul_result;
                  state_ff <= S_T1;
               end
            end
            S_T1: begin
               integ_ff <= integ_in;
               state_ff <= S_T1_W;
            end
            S_T1_W: begin
               if (mul_done) begin
                  t1_ff    <= mul_result;
                  state_ff <= S_T2;
               end
            end
            S_T2: state_ff <= S_T2_W;
            S_T2_W: begin
               if (mul_done) begin
                  num_ff   <= num_in;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: state_ff <= S_DIV_W;
            S_DIV_W: begin
               if (div_done) begin
                  d_ff     <= div_result;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               sum_ff   <= sum_in;
               state_ff <= S_DRIVE;
            end
            S_DRIVE: begin
               // Output clamp, upper limit first; flag only when beyond a limit
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (sum_ff > omax_ff) begin
                     rsp_drive_ff   <= omax_ff;
                     rsp_clamped_ff <= 1'b1;
                  end else if (sum_ff < omin_ff) begin
                     rsp_drive_ff   <= omin_ff;
                     rsp_clamped_ff <= 1'b1;
                  end else begin
                     rsp_drive_ff   <= sum_ff;
                     rsp_clamped_ff <= 1'b0;
                  end
                  integ_acc_ff  <= integ_ff;
                  deriv_acc_ff  <= d_ff;
                  last_error_ff <= err_ff;
                  last_meas_ff  <= meas_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = rsp_drive_ff;
   assign rsp_drive_clamped = rsp_clamped_ff;

   `PIDFD_ASSERT(a_mul_done_in_wait, mul_done |-> state_ff == S_PROP_W || state_ff == S_KITS_W || state_ff == S_ITERM_W || state_ff == S_T1_W || state_ff == S_T2_W, "product arrived outside a wait step")
   `PIDFD_ASSERT(a_div_done_in_wait, div_done |-> state_ff == S_DIV_W, "quotient arrived outside its wait step")
   `PIDFD_ASSERT(a_clear_zeroes, req_valid && req_ready && req_kind |=> integ_acc_ff == '0 && deriv_acc_ff == '0 && last_error_ff == '0 && last_meas_ff == '0, "clear left state")

endmodule

### tb/testbench.sv
// Self-checking testbench for the PID controller with trapezoidal integrator and filtered derivative.
`timescale 1ns / 1ps
module testbench;
   import pidfd_pkg::*;

   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -Q_HI - 1;
   localparam longint ONE  = 64'sd65536;

   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   localparam int SETTLE_CYCLES = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int BLOCKS        = 9;
   localparam int BLOCK_ITEMS   = 120;

   typedef struct packed {
      logic            kind;
      q_type           target;
      q_type           measured;
      logic [TS_W-1:0] sample_time;
   } step_item_type;

   typedef struct packed {
      csr_index_type index;
      logic [31:0]   data;
   } csr_write_type;

   typedef struct packed {
      q_type drive;
      logic  clamped;
   } drive_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic                 req_kind        = KIND_UPDATE;
   logic signed [31:0]   req_target      = '0;
   logic signed [31:0]   req_measured    = '0;
   logic [TS_W-1:0]      req_sample_time = '0;
   logic                 rsp_valid;
   logic                 rsp_ready       = 1'b0;
   logic signed [31:0]   rsp_drive;
   logic                 rsp_drive_clamped;
   logic                 csr_valid       = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index       = '0;
   logic [31:0]          csr_data        = '0;

   step_item_type    step_pending[$];
   csr_write_type    csr_pending[$];
   drive_result_type drive_expect[$];

   int          send_idle_pct = 7;
   int          recv_idle_pct = 51;
   int          fail_count    = 0;
   int unsigned stall_cycles  = 0;

   // Shadow of the configuration registers
   q_type            cfg_kp       = '0;
   q_type            cfg_ki       = '0;
   q_type            cfg_kd       = '0;
   logic [TAU_W-1:0] cfg_tau      = '0;
   q_type            cfg_integ_hi = q_type'(Q_HI);
   q_type            cfg_integ_lo = q_type'(Q_LO);
   q_type            cfg_drive_hi = q_type'(Q_HI);
   q_type            cfg_drive_lo = q_type'(Q_LO);

   // Controller state as the block should hold it
   q_type acc_integ = '0;
   q_type acc_deriv = '0;
   q_type prev_err  = '0;
   q_type prev_meas = '0;

   pid_filtered_derivative dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_target        (req_target),
      .req_measured      (req_measured),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_drive_clamped (rsp_drive_clamped),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- arithmetic

   function automatic longint clip_q(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
   endfunction

   // signed Q value from sign and magnitude, saturated
   function automatic longint mag_to_q(bit neg, logic [127:0] m);
      if (!neg) return (m > 128'h7FFF_FFFF) ? Q_HI : longint'(m[63:0]);
      if (m > 128'h8000_0000) return Q_LO;
      return -longint'(m[63:0]);
   endfunction

   // exact product, shifted right with truncation toward zero, saturated
   function automatic longint scaled_product(longint a, longint b, int unsigned sh);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      prod = 128'(ma) * 128'(mb);
      prod = prod >> sh;
      return mag_to_q((a < 0) != (b < 0), prod);
   endfunction

   // (num << FRAC_W) / den, den positive, truncation toward zero, saturated
   function automatic longint tustin_quotient(longint num, longint den);
      logic [63:0] m;
      logic [63:0] dv;
      logic [63:0] q;
      m  = (num < 0) ? -num : num;
      dv = den;
      q  = (m << FRAC_W) / dv;
      return mag_to_q(num < 0, {64'b0, q});
   endfunction

   // One update step: advances the controller state and queues the drive it produces
   function automatic void predict_update(q_type tgt, q_type meas, logic [TS_W-1:0] ts_raw);
      longint           ts, err, prop, kits, integ, t1, t2, num, den, d, sum;
      drive_result_type r;
      ts   = longint'(ts_raw);
      err  = clip_q(longint'(tgt) - longint'(meas));
      prop = scaled_product(longint'(cfg_kp), err, FRAC_W);

      // trapezoidal integrator, upper limit tested first
      kits  = scaled_product(longint'(cfg_ki), ts, FRAC_W);
      integ = clip_q(longint'(acc_integ)
                     + scaled_product(kits, err + longint'(prev_err), FRAC_W + 1));
      if (integ > longint'(cfg_integ_hi)) integ = longint'(cfg_integ_hi);
      else if (integ < longint'(cfg_integ_lo)) integ = longint'(cfg_integ_lo);

      // filtered derivative on the measurement
      t1  = scaled_product(longint'(cfg_kd), longint'(meas) - longint'(prev_meas), FRAC_W - 1);
      t2  = scaled_product(2 * longint'(cfg_tau) - ts, longint'(acc_deriv), FRAC_W);
      num = clip_q(t1 + t2);
      den = 2 * longint'(cfg_tau) + ts;
      d   = (den <= 0) ? 0 : clip_q(-tustin_quotient(num, den));

      // output clamp, flagged only beyond a limit
      sum       = clip_q(prop + integ + d);
      r.clamped = 1'b0;
      if (sum > longint'(cfg_drive_hi)) begin
         sum       = longint'(cfg_drive_hi);
         r.clamped = 1'b1;
      end else if (sum < longint'(cfg_drive_lo)) begin
         sum       = longint'(cfg_drive_lo);
         r.clamped = 1'b1;
      end

      acc_integ = q_type'(integ);
      acc_deriv = q_type'(d);
      prev_err  = q_type'(err);
      prev_meas = meas;
      r.drive   = q_type'(sum);
      drive_expect.push_back(r);
   endfunction

   // ---------------------------------------------------------------- channel drivers

   // Item channel: predicts on each transfer, loads the next pending item
   always @(posedge clock) begin : req_drive
      step_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_kind == KIND_CLEAR) begin
               acc_integ = '0;
               acc_deriv = '0;
               prev_err  = '0;
               prev_meas = '0;
            end else begin
               predict_update(req_target, req_measured, req_sample_time);
            end
         end
         if (!req_valid || req_ready) begin
            if (step_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               it = step_pending.pop_front();
               req_valid       <= 1'b1;
               req_kind        <= it.kind;
               req_target      <= it.target;
               req_measured    <= it.measured;
               req_sample_time <= it.sample_time;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Register channel: updates the shadow on each transfer
   always @(posedge clock) begin : csr_drive
      csr_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_GAIN_PROP:     cfg_kp       = csr_data;
               REG_GAIN_INTEGRAL: cfg_ki       = csr_data;
               REG_GAIN_DERIV:    cfg_kd       = csr_data;
               REG_FILTER_TAU:    cfg_tau      = csr_data[TAU_W-1:0];
               REG_INTEG_MAX:     cfg_integ_hi = csr_data;
               REG_INTEG_MIN:     cfg_integ_lo = csr_data;
               REG_DRIVE_MAX:     cfg_drive_hi = csr_data;
               REG_DRIVE_MIN:     cfg_drive_lo = csr_data;
               default: ;
            endcase
         end
         if (!csr_valid || csr_ready) begin
            if (csr_pending.size() != 0) begin
               w = csr_pending.pop_front();
               csr_valid <= 1'b1;
               csr_index <= w.index;
               csr_data  <= w.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Result channel: random backpressure, compare against the oldest expectation
   always @(posedge clock) begin : rsp_check
      drive_result_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_expect.size() == 0) begin
               $error("unexpected result: drive %0d clamped %0b", rsp_drive, rsp_drive_clamped);
               fail_count++;
            end else begin
               e = drive_expect.pop_front();
               if (rsp_drive !== e.drive) begin
                  $error("drive: expected %0d, got %0d", e.drive, rsp_drive);
                  fail_count++;
               end
               if (rsp_drive_clamped !== e.clamped) begin
                  $error("drive_clamped: expected %0b, got %0b", e.clamped, rsp_drive_clamped);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   task automatic push_update(longint t, longint m, longint ts);
      step_item_type it;
      it.kind        = KIND_UPDATE;
      it.target      = q_type'(t);
      it.measured    = q_type'(m);
      it.sample_time = TS_W'(ts);
      step_pending.push_back(it);
   endtask

   task automatic push_clear();
      step_item_type it;
      it.kind        = KIND_CLEAR;
      it.target      = q_type'($urandom);
      it.measured    = q_type'($urandom);
      it.sample_time = TS_W'($urandom);
      step_pending.push_back(it);
   endtask

   // sender holds until every expected result has come back
   task automatic wait_results_in();
      while (step_pending.size() != 0 || req_valid || drive_expect.size() != 0)
         @(negedge clock);
   endtask

   // idle block: results drained, then room for a clear still in progress
   task automatic settle();
      wait_results_in();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_setting(longint kp, longint ki, longint kd, logic [TAU_W-1:0] tau,
                                  longint ihi, longint ilo, longint dhi, longint dlo);
      csr_write_type w;
      w.index = REG_GAIN_PROP;     w.data = 32'(kp);                     csr_pending.push_back(w);
      w.index = REG_GAIN_INTEGRAL; w.data = 32'(ki);                     csr_pending.push_back(w);
      w.index = REG_GAIN_DERIV;    w.data = 32'(kd);                     csr_pending.push_back(w);
      w.index = REG_FILTER_TAU;    w.data = {1'($urandom_range(1)), tau}; csr_pending.push_back(w);
      w.index = REG_INTEG_MAX;     w.data = 32'(ihi);                    csr_pending.push_back(w);
      w.index = REG_INTEG_MIN;     w.data = 32'(ilo);                    csr_pending.push_back(w);
      w.index = REG_DRIVE_MAX;     w.data = 32'(dhi);                    csr_pending.push_back(w);
      w.index = REG_DRIVE_MIN;     w.data = 32'(dlo);                    csr_pending.push_back(w);
      while (csr_pending.size() != 0 || csr_valid) @(negedge clock);
   endtask

   // small signed value within +/- units
   function automatic longint rand_small(int unsigned units);
      longint m;
      m = longint'($urandom_range(0, units * 65536));
      return $urandom_range(1) ? -m : m;
   endfunction

   function automatic longint rand_signal();
      case ($urandom_range(9))
         0, 1:    return longint'(q_type'($urandom));
         2:       return Q_HI;
         3:       return Q_LO;
         default: return rand_small(40);
      endcase
   endfunction

   function automatic longint rand_gain();
      case ($urandom_range(7))
         0:       return Q_HI;
         1:       return Q_LO;
         2:       return 0;
         3:       return longint'(q_type'($urandom));
         default: return rand_small(4);
      endcase
   endfunction

   // normal, inverted or full-range limit pair
   task automatic pick_limits(output longint hi, output longint lo);
      longint a, b;
      a = rand_small(30);
      b = rand_small(30);
      case ($urandom_range(3))
         0: begin
            hi = Q_HI;
            lo = Q_LO;
         end
         1: begin
            hi = (a < b) ? a : b;
            lo = (a < b) ? b : a;
         end
         default: begin
            hi = (a < b) ? b : a;
            lo = (a < b) ? a : b;
         end
      endcase
   endtask

   // ---------------------------------------------------------------- test sequence

   initial begin : stimulus
      longint           ihi, ilo, dhi, dlo;
      logic [TAU_W-1:0] tau;
      logic [TS_W-1:0]  ts;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: zero gains, full-range limits
      push_update(Q_HI, Q_LO, '1);
      push_update(Q_LO, Q_HI, 0);
      settle();

      // unity gains, no filter
      program_setting(ONE, ONE, ONE, 0, Q_HI, Q_LO, Q_HI, Q_LO);
      push_update(Q_HI, Q_LO, '1);
      push_update(Q_LO, Q_HI, 0);           // zero divisor
      push_update(0, 0, 0);
      push_update(-1, 1, 1);
      push_clear();
      push_update(3 * ONE, ONE, 655);
      push_update(3 * ONE, -ONE, 655);
      settle();

      // extreme gains, longest filter, inverted integrator and drive limits
      program_setting(Q_LO, Q_HI, Q_LO, '1, -ONE, ONE, -2 * ONE, 2 * ONE);
      push_update(ONE, 0, ONE);
      push_update(-ONE, 2 * ONE, '1);
      push_update(Q_HI, Q_HI, 0);
      push_update(0, Q_LO, 1);
      settle();

      // pure proportional path against +/-5.0 drive limits
      program_setting(ONE, 0, 0, 0, Q_HI, Q_LO, 5 * ONE, -5 * ONE);
      push_clear();
      push_update(5 * ONE, 0, 100);          // lands on upper limit, no flag
      push_update(-5 * ONE, 0, 100);         // lands on lower limit, no flag
      push_update(5 * ONE + 1, 0, 100);
      push_update(0, 5 * ONE + 1, 100);
      push_update(0, 0, 0);
      settle();

      // random settings and items, three idling regimes
      for (int blk = 0; blk < BLOCKS; blk++) begin
         if (blk < 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 51;
         end else if (blk < 6) begin
            send_idle_pct = 51;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         case ($urandom_range(3))
            0:       tau = 0;
            1:       tau = '1;
            2:       tau = TAU_W'($urandom);
            default: tau = TAU_W'($urandom_range(0, 16384));
         endcase
         pick_limits(ihi, ilo);
         pick_limits(dhi, dlo);
         program_setting(rand_gain(), rand_gain(), rand_gain(), tau, ihi, ilo, dhi, dlo);

         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            if (n == BLOCK_ITEMS / 2) wait_results_in();
            case ($urandom_range(15))
               0:       ts = '0;
               1:       ts = '1;
               2, 3:    ts = TS_W'($urandom);
               default: ts = TS_W'($urandom_range(1, 13107));
            endcase
            if ($urandom_range(19) == 0) push_clear();
            else push_update(rand_signal(), rand_signal(), longint'(ts));
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
